// ----- hdl/rtc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the time-of-day clock
// Operation codes, queue entry layout and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // Seconds counter and prescaler widths
  localparam int CntW    = 32;
  localparam int ReloadW = 20;
  localparam int DayW    = 17;  // holds 0..86399

  localparam logic [ReloadW-1:0] ReloadReset = 20'd32767;

  // Clamp limits for set requests
  localparam logic [7:0] MaxHour   = 8'd23;
  localparam logic [7:0] MaxMinute = 8'd59;
  localparam logic [7:0] MaxSecond = 8'd59;

  // Stream action codes
  localparam logic [1:0] ActTick = 2'd0;
  localparam logic [1:0] ActSet  = 2'd1;
  localparam logic [1:0] ActGet  = 2'd2;

  // Constant-divisor reciprocals (floor/ceil chosen so one fix-up or none suffices)
  // 86400 = 675 << 7: (cnt >> 7) mod 675, floor(2^35/675)
  localparam logic [25:0] DayRecip  = 26'd50903316;
  localparam int          DayShift  = 35;
  // 3600 = 225 << 4: ceil(2^20/225), exact for dividend < 7037
  localparam logic [12:0] HourRecip = 13'd4661;
  // 60 = 15 << 2: ceil(2^14/15), exact for dividend < 1489
  localparam logic [10:0] MinRecip  = 11'd1093;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OpTick = 2'd0,
    OpSet  = 2'd1,
    OpGet  = 2'd2
  } rtc_op_e;

  typedef struct packed {
    rtc_op_e           op;
    logic [DayW-1:0]   set_secs;  // second of day for a set
  } rtc_entry_t;

  // Queue write side
  typedef struct packed {
    logic       valid;
    rtc_entry_t entry;
  } rtc_wr_t;

  // Queue read side
  typedef struct packed {
    logic       valid;
    rtc_entry_t entry;
  } rtc_rd_t;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

endpackage

// ----- hdl/rtc_front.sv -----
// ----------------------------------------------------------------------------
// rtc_front: request intake and classification
// Accepts stream requests, drops unused action codes, clamps set fields and
// forms the second of day for set requests.
// ----------------------------------------------------------------------------
module rtc_front
  import rtc_pkg::*;
(
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // hour_in[7:0], minute_in[15:8], second_in[23:16]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  input  logic        full_i,
  output rtc_wr_t     wr_o
);

  logic [7:0]      hour_c, min_c, sec_c;
  logic [DayW-1:0] secs_of_day;
  rtc_op_e         op;
  logic            keep;

  assign s_axis_tready = ~full_i;

  // Saturate the set fields
  always_comb begin
    hour_c = (s_axis_tdata[7:0]   > MaxHour)   ? MaxHour   : s_axis_tdata[7:0];
    min_c  = (s_axis_tdata[15:8]  > MaxMinute) ? MaxMinute : s_axis_tdata[15:8];
    sec_c  = (s_axis_tdata[23:16] > MaxSecond) ? MaxSecond : s_axis_tdata[23:16];
    secs_of_day = DayW'(hour_c) * DayW'(3600)
                + DayW'(min_c) * DayW'(60)
                + DayW'(sec_c);
  end

  // Classify the action; the unused code is swallowed
  always_comb begin
    keep = 1'b1;
    op   = OpTick;
    case (s_axis_tuser)
      ActTick: op = OpTick;
      ActSet:  op = OpSet;
      ActGet:  op = OpGet;
      default: keep = 1'b0;
    endcase
  end

  assign wr_o.valid          = s_axis_tvalid & ~full_i & keep;
  assign wr_o.entry.op       = op;
  assign wr_o.entry.set_secs = secs_of_day;

endmodule

// ----- hdl/rtc_fifo.sv -----
// ----------------------------------------------------------------------------
// rtc_fifo: small request queue between front and back
// Register-based FIFO; the head entry is presented combinationally.
// ----------------------------------------------------------------------------
module rtc_fifo
  import rtc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rtc_wr_t wr_i,
  output logic    full_o,
  output rtc_rd_t rd_o,
  input  logic    pop_i
);

  rtc_entry_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]    count_q;
  logic                  push, pop;

  assign full_o       = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign rd_o.valid   = (count_q != '0);
  assign rd_o.entry   = mem_q[rd_ptr_q];
  assign push         = wr_i.valid & ~full_o;
  assign pop          = pop_i & rd_o.valid;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hdl/rtc_back.sv -----
// ----------------------------------------------------------------------------
// rtc_back: clock state and time-of-day read pipeline
// Executes queued requests in order on the prescaler and seconds counter;
// reads are snapshotted and split into h:m:s over a pipelined datapath.
// ----------------------------------------------------------------------------
module rtc_back
  import rtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ReloadW-1:0] cfg_wdata_i,
  input  rtc_rd_t            rd_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata
);

  localparam int XW = CntW - 7;

  logic               en;
  logic [ReloadW-1:0] reload_q, div_q;
  logic [CntW-1:0]    cnt_q;

  // Read pipeline registers
  logic                 v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, out_v_q;
  logic [CntW-1:0]      snap_q;
  logic [XW+25:0]       prod2_q;
  logic [XW-1:0]        x2_q;
  logic [6:0]           lo2_q, lo3_q;
  logic [10:0]          rem3_q;
  logic [DayW-1:0]      day4_q, day5_q;
  logic [4:0]           hour5_q, hour6_q, hour7_q, hour_o_q;
  logic [11:0]          remh6_q, remh7_q;
  logic [5:0]           min7_q, min_o_q, sec_o_q;

  // Combinational stage results
  logic [15:0]          quo3;
  logic [25:0]          qm3;
  logic [XW-1:0]        rem3_full;
  logic [10:0]          rem4;
  logic [25:0]          hprod5;
  logic [DayW-1:0]      remh6_full;
  logic [20:0]          mprod7;
  logic [11:0]          sec8_full;

  // Whole back end advances unless the output holds an untaken result
  assign en    = ~out_v_q | m_axis_tready;
  assign pop_o = en & rd_i.valid;

  // Prescaler reload register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= ReloadReset;
    end else if (cfg_we_i) begin
      reload_q <= cfg_wdata_i;
    end
  end

  // Execute tick and set on the clock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
      cnt_q <= '0;
    end else if (pop_o) begin
      case (rd_i.entry.op)
        OpTick: begin
          if (div_q >= reload_q) begin
            div_q <= '0;
            cnt_q <= cnt_q + 1'b1;
          end else begin
            div_q <= div_q + 1'b1;
          end
        end
        OpSet:   cnt_q <= CntW'(rd_i.entry.set_secs);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Stage combinational math
  always_comb begin
    quo3       = prod2_q[DayShift +: 16];
    qm3        = quo3 * 26'd675;
    rem3_full  = x2_q - qm3[XW-1:0];
    rem4       = (rem3_q >= 11'd675) ? (rem3_q - 11'd675) : rem3_q;
    hprod5     = day4_q[DayW-1:4] * HourRecip;
    remh6_full = day5_q - DayW'(hour5_q) * DayW'(3600);
    mprod7     = remh6_q[11:2] * MinRecip;
    sec8_full  = remh7_q - 12'(min7_q) * 12'd60;
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= pop_o & (rd_i.entry.op == OpGet);
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      out_v_q <= v7_q;
    end
  end

  // Datapath: mod 86400, then hour, minute and second
  always_ff @(posedge clk_i) begin
    if (en) begin
      snap_q   <= cnt_q;
      prod2_q  <= snap_q[CntW-1:7] * DayRecip;
      x2_q     <= snap_q[CntW-1:7];
      lo2_q    <= snap_q[6:0];
      rem3_q   <= rem3_full[10:0];
      lo3_q    <= lo2_q;
      day4_q   <= {rem4[9:0], lo3_q};
      day5_q   <= day4_q;
      hour5_q  <= hprod5[24:20];
      remh6_q  <= remh6_full[11:0];
      hour6_q  <= hour5_q;
      min7_q   <= mprod7[19:14];
      remh7_q  <= remh6_q;
      hour7_q  <= hour6_q;
      if (v7_q) begin
        hour_o_q <= hour7_q;
        min_o_q  <= min7_q;
        sec_o_q  <= sec8_full[5:0];
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, sec_o_q, min_o_q, hour_o_q};

endmodule

// ----- hdl/time_of_day_rtc_top.sv -----
// ----------------------------------------------------------------------------
// time_of_day_rtc_top: time-of-day clock with prescaler and seconds counter
// Front classifies requests, a four-entry queue decouples it from the back,
// which updates the counter and converts reads to hours, minutes, seconds.
// ----------------------------------------------------------------------------
// Throughput: one request of any kind, ticks included, per cycle while the queue is not full.
// Read path: a request passes through the queue, then through an eight-stage
//   divide-by-constant pipeline, before its result appears.
// A stalled output freezes the back end; the queue keeps intake going for up to 4 more requests.
// Reset (async, active low): counter and divider zero, reload 32767, queue empty.
// ----------------------------------------------------------------------------
module time_of_day_rtc_top
  import rtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ReloadW-1:0] cfg_wdata_i,     // prescaler_reload[19:0]
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,    // hour_in[7:0], minute_in[15:8], second_in[23:16]
  input  logic [1:0]         s_axis_tuser,    // action[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata     // hour_out[4:0], minute_out[10:5],
                                              // second_out[16:11], zero[23:17]
);

  rtc_wr_t wr;
  rtc_rd_t rd;
  logic    full, pop;

  // Request intake
  rtc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .wr_o          (wr)
  );

  // Decoupling queue
  rtc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .full_o (full),
    .rd_o   (rd),
    .pop_i  (pop)
  );

  // Clock state and read conversion
  rtc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rd_i          (rd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
